@@ rtl/sorted_list_engine_core_defines.svh @@
// assertion macros for the sorted list engine
`ifndef SORTED_LIST_ENGINE_CORE_DEFINES_SVH
`define SORTED_LIST_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SLE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sle assertion failed");
`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sle assertion failed");
`else
`define SLE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/sle_pkg.sv @@
// shared types, codes and command/status structs of the sorted list engine
package sle_pkg;
   localparam int unsigned DEPTH_DEFAULT = 256;
   localparam int unsigned INDEX_W       = 8;
   localparam int unsigned COUNT_W       = 9;

   typedef logic [1:0]         opcode_type;
   typedef logic signed [31:0] value_type;
   typedef logic [7:0]         index_type;
   typedef logic [1:0]         status_type;
   typedef logic [8:0]         count_type;
   typedef logic [1:0]         rd_sel_type;

   localparam opcode_type OP_INSERT = 2'd0;
   localparam opcode_type OP_REMOVE = 2'd1;
   localparam opcode_type OP_SUM    = 2'd2;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_BAD_INDEX = 2'd1;
   localparam status_type ST_FULL      = 2'd2;

   // read address sources
   localparam rd_sel_type RD_INDEX_A = 2'd0;
   localparam rd_sel_type RD_INDEX_B = 2'd1;
   localparam rd_sel_type RD_BELOW   = 2'd2;
   localparam rd_sel_type RD_ABOVE   = 2'd3;

   typedef struct packed {
      logic       load_cmd;
      logic       set_status;
      status_type status;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       load_addend;
      logic       load_sum;
      logic       ptr_from_count;
      logic       ptr_from_a;
      logic       ptr_dec;
      logic       ptr_inc;
      logic       wr_en;
      logic       wr_from_value;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       load_removed;
      logic       rsp_load;
   } sle_cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       full;
      logic       empty;
      logic       bad_a;
      logic       bad_ab;
      logic       ptr_zero;
      logic       more_above;
      logic       greater;
      logic       rsp_busy;
   } sle_stat_type;
endpackage

@@ rtl/sle_req_if.sv @@
// command channel interface
interface sle_req_if;
   import sle_pkg::*;
   logic       valid;
   logic       ready;
   opcode_type opcode;
   value_type  value;
   index_type  index_a;
   index_type  index_b;
   modport source (output valid, opcode, value, index_a, index_b, input ready);
   modport sink (input valid, opcode, value, index_a, index_b, output ready);
endinterface

@@ rtl/sle_rsp_if.sv @@
// result channel interface
interface sle_rsp_if;
   import sle_pkg::*;
   logic       valid;
   logic       ready;
   status_type status;
   value_type  removed_value;
   count_type  count;
   modport source (output valid, status, removed_value, count, input ready);
   modport sink (input valid, status, removed_value, count, output ready);
endinterface

@@ rtl/sle_datapath.sv @@
// table memory, count, pointer and result register of the sorted list engine
module sle_datapath #(
   parameter int unsigned DEPTH = sle_pkg::DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sle_pkg::sle_cmd_type cmd,
   output sle_pkg::sle_stat_type stat,
   input  sle_pkg::opcode_type  req_opcode,
   input  sle_pkg::value_type   req_value,
   input  sle_pkg::index_type   req_index_a,
   input  sle_pkg::index_type   req_index_b,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sle_pkg::status_type  rsp_status,
   output sle_pkg::value_type   rsp_removed_value,
   output sle_pkg::count_type   rsp_count
);
   import sle_pkg::*;

   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW   = $clog2(DEPTH + 1);
   localparam int unsigned CMPW = (CW > INDEX_W) ? CW : INDEX_W;

   logic [31:0]   entries_mem [DEPTH];
   logic [31:0]   rdata_ff;
   logic [AW-1:0] raddr;
   logic [AW-1:0] waddr;
   logic [31:0]   wdata;

   opcode_type  op_ff, op_in;
   value_type   value_ff, value_in;
   index_type   ia_ff, ia_in;
   index_type   ib_ff, ib_in;
   logic [31:0] addend_ff, addend_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] count_ff, count_in;
   status_type  status_ff, status_in;
   value_type   removed_ff, removed_in;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   value_type   rsp_removed_ff, rsp_removed_in;
   count_type   rsp_count_ff, rsp_count_in;

   logic [CW-1:0] ptr_below;
   logic [CW-1:0] ptr_above;

   assign ptr_below = ptr_ff - CW'(1);
   assign ptr_above = ptr_ff + CW'(1);

   always_comb begin
      unique case (cmd.rd_sel)
         RD_INDEX_A: raddr = AW'(ia_ff);
         RD_INDEX_B: raddr = AW'(ib_ff);
         RD_BELOW:   raddr = AW'(ptr_below);
         RD_ABOVE:   raddr = AW'(ptr_above);
         default:    raddr = AW'(ia_ff);
      endcase
   end

   assign waddr = AW'(ptr_ff);
   assign wdata = cmd.wr_from_value ? value_ff : rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entries_mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= entries_mem[raddr];
      end
   end

   always_comb begin
      op_in          = op_ff;
      value_in       = value_ff;
      ia_in          = ia_ff;
      ib_in          = ib_ff;
      addend_in      = addend_ff;
      ptr_in         = ptr_ff;
      count_in       = count_ff;
      status_in      = status_ff;
      removed_in     = removed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_count_in   = rsp_count_ff;
      if (cmd.load_cmd) begin
         op_in      = req_opcode;
         value_in   = req_value;
         ia_in      = req_index_a;
         ib_in      = req_index_b;
         status_in  = ST_OK;
         removed_in = '0;
      end
      if (cmd.set_status) begin
         status_in = cmd.status;
      end
      if (cmd.load_addend) begin
         addend_in = rdata_ff;
      end
      if (cmd.load_sum) begin
         value_in = addend_ff + rdata_ff;
      end
      if (cmd.load_removed) begin
         removed_in = rdata_ff;
      end
      if (cmd.ptr_from_count) begin
         ptr_in = count_ff;
      end else if (cmd.ptr_from_a) begin
         ptr_in = CW'(ia_ff);
      end else if (cmd.ptr_dec) begin
         ptr_in = ptr_below;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_above;
      end
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = status_ff;
         rsp_removed_in = removed_ff;
         rsp_count_in   = COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      value_ff       <= value_in;
      ia_ff          <= ia_in;
      ib_ff          <= ib_in;
      addend_ff      <= addend_in;
      ptr_ff         <= ptr_in;
      status_ff      <= status_in;
      removed_ff     <= removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign stat.opcode     = op_ff;
   assign stat.full       = (count_ff == CW'(DEPTH));
   assign stat.empty      = (count_ff == '0);
   assign stat.bad_a      = (CMPW'(ia_ff) >= CMPW'(count_ff));
   assign stat.bad_ab     = stat.bad_a || (CMPW'(ib_ff) >= CMPW'(count_ff));
   assign stat.ptr_zero   = (ptr_ff == '0);
   assign stat.more_above = (ptr_above < count_ff);
   assign stat.greater    = ($signed(rdata_ff) > value_ff);
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_count         = rsp_count_ff;
endmodule

@@ rtl/sle_controller.sv @@
// command sequencer of the sorted list engine
module sle_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sle_pkg::sle_stat_type stat,
   output sle_pkg::sle_cmd_type  cmd
);
   import sle_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_SUM_A    = 4'd2;
   localparam logic [3:0] S_SUM_B    = 4'd3;
   localparam logic [3:0] S_INS_STEP = 4'd4;
   localparam logic [3:0] S_INS_CMP  = 4'd5;
   localparam logic [3:0] S_REM_HEAD = 4'd6;
   localparam logic [3:0] S_REM_STEP = 4'd7;
   localparam logic [3:0] S_REM_MOVE = 4'd8;
   localparam logic [3:0] S_FINISH   = 4'd9;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_cmd = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.opcode)
               OP_INSERT: begin
                  if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.ptr_from_count = 1'b1;
                     state_in           = S_INS_STEP;
                  end
               end
               OP_REMOVE: begin
                  if (stat.bad_a) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_BAD_INDEX;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_INDEX_A;
                     state_in   = S_REM_HEAD;
                  end
               end
               OP_SUM: begin
                  if (stat.bad_ab) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_BAD_INDEX;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_INDEX_A;
                     state_in   = S_SUM_A;
                  end
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_SUM_A: begin
            cmd.load_addend = 1'b1;
            cmd.rd_en       = 1'b1;
            cmd.rd_sel      = RD_INDEX_B;
            state_in        = S_SUM_B;
         end
         S_SUM_B: begin
            cmd.load_sum = 1'b1;
            if (stat.full) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_FULL;
               state_in       = S_FINISH;
            end else begin
               cmd.ptr_from_count = 1'b1;
               state_in           = S_INS_STEP;
            end
         end
         S_INS_STEP: begin
            if (stat.ptr_zero) begin
               cmd.wr_en         = 1'b1;
               cmd.wr_from_value = 1'b1;
               cmd.cnt_inc       = 1'b1;
               state_in          = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_BELOW;
               state_in   = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            cmd.wr_en = 1'b1;
            if (stat.greater) begin
               cmd.ptr_dec = 1'b1;
               state_in    = S_INS_STEP;
            end else begin
               cmd.wr_from_value = 1'b1;
               cmd.cnt_inc       = 1'b1;
               state_in          = S_FINISH;
            end
         end
         S_REM_HEAD: begin
            cmd.load_removed = 1'b1;
            cmd.ptr_from_a   = 1'b1;
            state_in         = S_REM_STEP;
         end
         S_REM_STEP: begin
            if (stat.more_above) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ABOVE;
               state_in   = S_REM_MOVE;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_FINISH;
            end
         end
         S_REM_MOVE: begin
            cmd.wr_en   = 1'b1;
            cmd.ptr_inc = 1'b1;
            state_in    = S_REM_STEP;
         end
         S_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

@@ rtl/sorted_list_engine_core.sv @@
// top level of the sorted list engine: ascending table with insert, remove and sum
//
//   channel | dir | beat
//   req_bus | in  | opcode, value, index_a, index_b
//   rsp_bus | out | status, removed_value, count
//
// one command at a time; each beat in gives exactly one beat out
// insert: walks down from the end, moving up each greater entry, and writes the value into the gap
// sum first reads both operands and then inserts their sum; remove: moves each entry above index_a down
// errors and unused opcode go from decode straight to finish; a sum refused by a full table reads both operands first
// each entry moved is a read and then a write through the single registered read port of the table memory
// synchronous reset empties the table at once by clearing the count; no clearing pass
// a held result stalls only the finish of the next command, which may already be taken
`include "sorted_list_engine_core_defines.svh"
module sorted_list_engine_core #(
   parameter int unsigned DEPTH = sle_pkg::DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   sle_req_if.sink    req_bus,
   sle_rsp_if.source  rsp_bus
);
   import sle_pkg::*;

   sle_cmd_type  cmd;
   sle_stat_type stat;

   // sequencer: walks one command through the table
   sle_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table memory, count and result register
   sle_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_bus.opcode),
      .req_value         (req_bus.value),
      .req_index_a       (req_bus.index_a),
      .req_index_b       (req_bus.index_b),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_status        (rsp_bus.status),
      .rsp_removed_value (rsp_bus.removed_value),
      .rsp_count         (rsp_bus.count)
   );

   // a taken beat is decoded first and never finishes right away
   `SLE_ASSERT_NEXT(a_no_early_finish, clock, reset, req_bus.valid && req_bus.ready, !cmd.rsp_load)
   // growth only below capacity, shrink only from a non-empty table
   `SLE_ASSERT_IMPL(a_grow_not_full, clock, reset, cmd.cnt_inc, !stat.full)
   `SLE_ASSERT_IMPL(a_shrink_not_empty, clock, reset, cmd.cnt_dec, !stat.empty)
   // a result never overwrites one still waiting
   `SLE_ASSERT_IMPL(a_no_overwrite, clock, reset, cmd.rsp_load, !stat.rsp_busy)
endmodule

@@ test/sle_tb_pkg.sv @@
// testbench-side item types for the sorted list engine
package sle_tb_pkg;
   import sle_pkg::*;

   typedef struct {
      opcode_type opcode;
      value_type  value;
      index_type  index_a;
      index_type  index_b;
   } command_type;

   typedef struct {
      status_type status;
      value_type  removed_value;
      count_type  count;
   } outcome_type;
endpackage

@@ test/tb_sorted_list_engine_core.sv @@
// self-checking testbench of the sorted list engine core
module tb_sorted_list_engine_core;
   timeunit 1ns;
   timeprecision 1ps;
   import sle_pkg::*;
   import sle_tb_pkg::*;

   localparam int TABLE_DEPTH = 256;
   // watchdog limit, padded generously for the slowest commands
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int DRAIN_CYCLES = 1200;
   // opcode with no function: no change, ok status
   localparam opcode_type OP_SPARE = 2'd3;

   logic clock;
   logic reset;

   sle_req_if req_bus ();
   sle_rsp_if rsp_bus ();

   sorted_list_engine_core #(.DEPTH(TABLE_DEPTH)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   // predictor state: shadow copy of the sorted table
   value_type shadow_table[$];

   command_type pending_commands[$];
   outcome_type expected_outcomes[$];

   int mismatch_count;
   int cycle_count;
   bit stimulus_done;
   int long_hold_cycles;   // receiver long hold-off, counted in the monitor

   bit burst_mode;       // sender offers back to back
   bit pause_for_drain;  // sender holds until all results are back
   bit accepted_last;
   bit rsp_taken;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // insert in order: after any equal entries; full table refuses
   function automatic status_type place_in_order(value_type v);
      int pos;
      pos = 0;
      if (shadow_table.size() >= TABLE_DEPTH) begin
         return ST_FULL;
      end
      while (pos < shadow_table.size() && !(shadow_table[pos] > v)) begin
         pos++;
      end
      shadow_table.insert(pos, v);
      return ST_OK;
   endfunction

   function automatic outcome_type predict_outcome(command_type c);
      outcome_type o;
      o.status = ST_OK;
      o.removed_value = '0;
      case (c.opcode)
         OP_INSERT: begin
            o.status = place_in_order(c.value);
         end
         OP_REMOVE: begin
            if (c.index_a >= shadow_table.size()) begin
               o.status = ST_BAD_INDEX;
            end else begin
               o.removed_value = shadow_table[c.index_a];
               shadow_table.delete(c.index_a);
            end
         end
         OP_SUM: begin
            // index check comes before the full check
            if (c.index_a >= shadow_table.size() || c.index_b >= shadow_table.size()) begin
               o.status = ST_BAD_INDEX;
            end else begin
               o.status = place_in_order(shadow_table[c.index_a] + shadow_table[c.index_b]);
            end
         end
         default: begin
            // unused opcode: no change, ok status
         end
      endcase
      o.count = count_type'(shadow_table.size());
      return o;
   endfunction

   task automatic queue_command(opcode_type op, value_type v, index_type a, index_type b);
      command_type c;
      c.opcode = op;
      c.value = v;
      c.index_a = a;
      c.index_b = b;
      pending_commands.push_back(c);
   endtask

   function automatic value_type random_value();
      case ($urandom_range(0, 5))
         0: return 32'sh7fff_ffff - value_type'($urandom_range(0, 3));
         1: return 32'sh8000_0000 + value_type'($urandom_range(0, 3));
         2: return value_type'($urandom_range(0, 20)) - 10;
         default: return value_type'($urandom());
      endcase
   endfunction

   // indices mostly inside the table, sometimes just past or anywhere
   function automatic index_type random_index(int size);
      case ($urandom_range(0, 9))
         0: return index_type'($urandom_range(0, 255));
         1: return index_type'(size);
         default: return (size == 0) ? index_type'(0) : index_type'($urandom_range(0, size - 1));
      endcase
   endfunction

   // driver: beats change at the falling edge, each item after a random gap unless in burst mode
   int gap_left;
   bit gap_drawn;
   command_type drive_item;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_INSERT;
      req_bus.value = '0;
      req_bus.index_a = '0;
      req_bus.index_b = '0;
      gap_drawn = 1'b0;
      gap_left = 0;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !accepted_last) begin
         // still waiting for the handshake, hold the beat
      end else begin
         if (!gap_drawn) begin
            gap_left = (pause_for_drain || pending_commands.size() == 0)
                       ? 0 : ((burst_mode) ? 0 : $urandom_range(0, 8));
            gap_drawn = 1'b1;
         end
         if (pause_for_drain || pending_commands.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else begin
            drive_item = pending_commands.pop_front();
            expected_outcomes.push_back(predict_outcome(drive_item));
            req_bus.valid <= 1'b1;
            req_bus.opcode <= drive_item.opcode;
            req_bus.value <= drive_item.value;
            req_bus.index_a <= drive_item.index_a;
            req_bus.index_b <= drive_item.index_b;
            gap_drawn = 1'b0;
         end
      end
   end

   // accept flag sampled at the rising edge for the driver
   always @(posedge clock) begin
      accepted_last <= req_bus.valid && req_bus.ready && !reset;
   end

   // monitor: ready changes at the falling edge, beats checked at the rising edge
   int stall_left;
   bit stall_drawn;
   initial begin
      rsp_bus.ready = 1'b0;
      stall_drawn = 1'b0;
      stall_left = 0;
      long_hold_cycles = 0;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (long_hold_cycles > 0) begin
         long_hold_cycles--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_bus.ready && !rsp_taken) begin
         // keep ready high until a beat goes through
      end else begin
         if (!stall_drawn) begin
            stall_left = burst_mode ? 0 : $urandom_range(0, 8);
            stall_drawn = 1'b1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_drawn = 1'b0;
         end
      end
   end

   outcome_type expected_now;
   always @(posedge clock) begin
      rsp_taken <= 1'b0;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_taken <= 1'b1;
         if (expected_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected beat: status %0d removed %0d count %0d",
                        rsp_bus.status, rsp_bus.removed_value, rsp_bus.count);
            end
         end else begin
            expected_now = expected_outcomes.pop_front();
            if (rsp_bus.status !== expected_now.status
                || rsp_bus.removed_value !== expected_now.removed_value
                || rsp_bus.count !== expected_now.count) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: exp status %0d removed %0d count %0d, got %0d %0d %0d",
                           expected_now.status, expected_now.removed_value,
                           expected_now.count, rsp_bus.status,
                           rsp_bus.removed_value, rsp_bus.count);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_commands.size() != 0 || expected_outcomes.size() != 0 || req_bus.valid) begin
         @(posedge clock);
      end
   endtask

   // stimulus
   int n;
   int sim_size;
   opcode_type op;
   initial begin
      burst_mode = 1'b0;
      pause_for_drain = 1'b0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: errors on the empty table, unused opcode
      queue_command(OP_REMOVE, '0, 8'd0, 8'd0);
      queue_command(OP_SUM, '0, 8'd0, 8'd0);
      queue_command(OP_SPARE, 32'sh5a5a_a5a5, 8'hff, 8'hff);
      // extremes and equal values (equal ones go after existing)
      queue_command(OP_INSERT, 32'sh7fff_ffff, 8'hff, 8'hff);
      queue_command(OP_INSERT, 32'sh8000_0000, 8'd0, 8'd0);
      queue_command(OP_INSERT, 32'sd0, 8'd0, 8'd0);
      queue_command(OP_INSERT, -32'sd1, 8'd0, 8'd0);
      queue_command(OP_INSERT, 32'sd0, 8'd0, 8'd0);
      // sum overflow: max + max wraps, min + min wraps; then bad-index sums, and removes both in and out of range
      queue_command(OP_SUM, '0, 8'd4, 8'd4);
      queue_command(OP_SUM, '0, 8'd0, 8'd0);
      queue_command(OP_SUM, '0, 8'd1, 8'd255);
      queue_command(OP_SUM, '0, 8'd255, 8'd1);
      queue_command(OP_REMOVE, '0, 8'd7, 8'd0);
      queue_command(OP_REMOVE, '0, 8'd0, 8'd0);
      queue_command(OP_REMOVE, '0, 8'd2, 8'd0);
      queue_command(OP_REMOVE, '0, 8'd200, 8'd0);
      wait_drained();

      // fill to full, then full refusals for insert and sum, with receiver hold-off
      pause_for_drain = 1'b0;
      burst_mode = 1'b1;
      long_hold_cycles = 400;
      sim_size = shadow_table.size();
      while (sim_size < TABLE_DEPTH) begin
         queue_command(OP_INSERT, random_value(), 8'd0, 8'd0);
         sim_size++;
      end
      queue_command(OP_INSERT, 32'sd1, 8'd0, 8'd0);
      queue_command(OP_SUM, '0, 8'd255, 8'd0);
      queue_command(OP_SUM, '0, 8'd255, 8'd255);
      wait_drained();
      burst_mode = 1'b0;
      sim_size = shadow_table.size();

      // drain down to empty while removing at both ends
      while (sim_size > 0) begin
         queue_command(OP_REMOVE, '0,
                       ($urandom_range(0, 1)) ? index_type'(sim_size - 1) : 8'd0, 8'd0);
         sim_size--;
      end
      // part way through, the sender pauses until everything is back
      repeat (300) @(posedge clock);
      pause_for_drain = 1'b1;
      while (expected_outcomes.size() != 0 || req_bus.valid) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      pause_for_drain = 1'b0;
      wait_drained();
      sim_size = shadow_table.size();

      // random: small tables mostly, a biased walk of inserts and removes
      for (n = 0; n < 225; n++) begin
         if (n % 250 == 125) begin
            burst_mode = 1'b1;
            long_hold_cycles = 300;
         end
         if (n % 250 == 200) begin
            burst_mode = 1'b0;
         end
         op = opcode_type'($urandom_range(0, 9) < 4 ? OP_INSERT
              : ($urandom_range(0, 9) < 6 ? OP_REMOVE
              : ($urandom_range(0, 19) == 0 ? OP_SPARE : OP_SUM)));
         if (sim_size > 40 && op == OP_INSERT) begin
            op = OP_REMOVE;
         end
         queue_command(op, random_value(), random_index(sim_size), random_index(sim_size));
         if (op == OP_INSERT) begin
            sim_size++;
         end
         // keep the rough size estimate honest via the predictor at drain points
         if (n % 50 == 49) begin
            wait_drained();
            sim_size = shadow_table.size();
         end
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
